// ----- rtl/i2rt_pkg.sv -----
// Shared types, codes and helpers for the integer to radix text unit.
package i2rt_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_SIGN,
        ST_READ,
        ST_DIGIT,
        ST_ERROR
    } t_state;

    localparam logic [5:0] BASE_MIN   = 6'd2;
    localparam logic [5:0] BASE_MAX   = 6'd36;
    localparam logic [5:0] DIGIT_TEN  = 6'hA;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;  // '0'
    localparam logic [7:0] CHAR_UPPER = 8'h41;  // 'A'
    localparam logic [7:0] CHAR_MINUS = 8'h2D;  // '-'
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;  // '+'

    function automatic logic [7:0] digit_char(input logic [5:0] d);
        logic [7:0] c;
        if (d < DIGIT_TEN) begin
            c = CHAR_ZERO + {2'b00, d};
        end else begin
            c = CHAR_UPPER + {2'b00, d - DIGIT_TEN};
        end
        return c;
    endfunction

endpackage

// ----- rtl/integer_to_radix_text_unit.sv -----
// Top level: 32-bit integer to ASCII text in radix 2..36, bit-serial divider.
//
//  channel   dir  payload (low bit up)                               handshake
//  i_s_*     in   tdata: value[31:0] base[37:32] limit[43:38] show[44]   tvalid/tready
//                 tuser: kind
//  o_m_*     out  tdata: character[7:0]; tlast: last; tuser: error       tvalid/tready
//
// Each digit takes one pass of the shared restoring divide step over all 32 quotient bits
// (one compare/subtract per quotient bit).
// Each digit character passes through ST_READ for the registered digit memory read, then waits for tready.
// One item in flight; the input is ready only when idle. Reset is synchronous, active low.
module integer_to_radix_text_unit #(
    parameter int MAX_DIGITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [47:0] i_s_tdata,   // value[31:0], base[37:32], digit_limit[43:38], show_sign[44]
    input  logic        i_s_tuser,   // kind
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // character[7:0]
    output logic        o_m_tlast,   // last
    output logic        o_m_tuser    // error
);

    localparam int IDX_W = $clog2(MAX_DIGITS);
    localparam int CNT_W = $clog2(MAX_DIGITS + 1);

    i2rt_pkg::t_state r_state, n_state;

    logic [31:0]      r_q;
    logic [5:0]       r_rem;
    logic [5:0]       r_base;
    logic [4:0]       r_bit;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] r_lim;
    logic [IDX_W-1:0] r_idx;
    logic             r_neg;
    logic             r_show;
    logic [5:0]       r_rd_data;

    logic [5:0] mem_digits [MAX_DIGITS];

    // input fields
    logic [31:0] in_value;
    logic [5:0]  in_base;
    logic [5:0]  in_limit;
    logic        in_show;
    logic        in_bad;
    logic        in_neg;
    logic        s_xfer;
    logic        m_xfer;

    assign in_value = i_s_tdata[31:0];
    assign in_base  = i_s_tdata[37:32];
    assign in_limit = i_s_tdata[43:38];
    assign in_show  = i_s_tdata[44];
    assign in_bad   = (in_base < i2rt_pkg::BASE_MIN) || (in_base > i2rt_pkg::BASE_MAX)
                      || (in_limit == 6'd0);
    assign in_neg   = i_s_tuser & in_value[31];
    assign s_xfer   = i_s_tvalid && o_s_tready;
    assign m_xfer   = o_m_tvalid && i_m_tready;

    // shared divide step: one quotient bit per cycle
    logic [6:0]       div_trial;
    logic             div_ge;
    logic [5:0]       div_rem;
    logic [31:0]      div_q;
    logic             div_last;
    logic [CNT_W-1:0] cnt_inc;
    logic             div_more;

    assign div_trial = {r_rem, r_q[31]};
    assign div_ge    = div_trial >= {1'b0, r_base};
    assign div_rem   = div_ge ? 6'(div_trial - {1'b0, r_base}) : div_trial[5:0];
    assign div_q     = {r_q[30:0], div_ge};
    assign div_last  = (r_bit == 5'd31);
    assign cnt_inc   = r_cnt + CNT_W'(1);
    assign div_more  = (cnt_inc < r_lim) && (div_q != 32'd0);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            i2rt_pkg::ST_IDLE: begin
                if (s_xfer) begin
                    n_state = in_bad ? i2rt_pkg::ST_ERROR : i2rt_pkg::ST_DIVIDE;
                end
            end
            i2rt_pkg::ST_DIVIDE: begin
                if (div_last && !div_more) begin
                    n_state = r_show ? i2rt_pkg::ST_SIGN : i2rt_pkg::ST_READ;
                end
            end
            i2rt_pkg::ST_SIGN: begin
                if (m_xfer) n_state = i2rt_pkg::ST_READ;
            end
            i2rt_pkg::ST_READ: begin
                n_state = i2rt_pkg::ST_DIGIT;
            end
            i2rt_pkg::ST_DIGIT: begin
                if (m_xfer) begin
                    n_state = (r_idx == '0) ? i2rt_pkg::ST_IDLE : i2rt_pkg::ST_READ;
                end
            end
            i2rt_pkg::ST_ERROR: begin
                if (m_xfer) n_state = i2rt_pkg::ST_IDLE;
            end
            default: n_state = i2rt_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_s_tready = 1'b0;
        o_m_tvalid = 1'b0;
        o_m_tdata  = 8'd0;
        o_m_tlast  = 1'b0;
        o_m_tuser  = 1'b0;
        unique case (r_state)
            i2rt_pkg::ST_IDLE: begin
                o_s_tready = 1'b1;
            end
            i2rt_pkg::ST_SIGN: begin
                o_m_tvalid = 1'b1;
                o_m_tdata  = r_neg ? i2rt_pkg::CHAR_MINUS : i2rt_pkg::CHAR_PLUS;
            end
            i2rt_pkg::ST_DIGIT: begin
                o_m_tvalid = 1'b1;
                o_m_tdata  = i2rt_pkg::digit_char(r_rd_data);
                o_m_tlast  = (r_idx == '0);
            end
            i2rt_pkg::ST_ERROR: begin
                o_m_tvalid = 1'b1;
                o_m_tlast  = 1'b1;
                o_m_tuser  = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= i2rt_pkg::ST_IDLE;
            r_cnt   <= '0;
            r_q     <= '0;
            r_neg   <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == i2rt_pkg::ST_IDLE && s_xfer && !in_bad) begin
                r_neg <= in_neg;
                r_q   <= in_neg ? 32'(32'd0 - in_value) : in_value;
                r_cnt <= '0;
            end else if (r_state == i2rt_pkg::ST_DIVIDE) begin
                r_q <= div_q;
                if (div_last) begin
                    r_cnt <= cnt_inc;
                    r_idx <= r_cnt[IDX_W-1:0];
                end
            end else if (r_state == i2rt_pkg::ST_DIGIT && m_xfer && r_idx != '0) begin
                r_idx <= r_idx - IDX_W'(1);
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (r_state == i2rt_pkg::ST_IDLE && s_xfer) begin
            r_base <= in_base;
            r_show <= i_s_tuser & in_show;
            r_rem  <= '0;
            r_bit  <= '0;
            if (int'(in_limit) > MAX_DIGITS) begin
                r_lim <= CNT_W'(MAX_DIGITS);
            end else begin
                r_lim <= CNT_W'(in_limit);
            end
        end else if (r_state == i2rt_pkg::ST_DIVIDE) begin
            r_bit <= r_bit + 5'd1;
            r_rem <= div_last ? 6'd0 : div_rem;
        end
    end

    // digit memory, written low digit first, read back high digit first
    always_ff @(posedge i_clk) begin
        if (r_state == i2rt_pkg::ST_DIVIDE && div_last) begin
            mem_digits[r_cnt[IDX_W-1:0]] <= div_rem;
        end
        r_rd_data <= mem_digits[r_idx];
    end

    a_ready_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready |-> !o_m_tvalid)
        else $error("input ready while a result is pending");

    a_err_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> (o_m_tlast && o_m_tdata == 8'd0))
        else $error("error result not last or nonzero");

    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == i2rt_pkg::ST_DIVIDE) |-> (r_rem < r_base))
        else $error("partial remainder out of range");

    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == i2rt_pkg::ST_DIGIT) |-> (r_rd_data < r_base))
        else $error("stored digit not below base");

    a_cnt_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == i2rt_pkg::ST_DIVIDE) |-> (r_cnt < r_lim))
        else $error("digit count passed limit");

endmodule
